// ----- design/assert_macros.svh -----
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define FERRT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define FERRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FERRT_ASSERT(label, clk, rst_n, prop)
`define FERRT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- design/ferrt_pkg.sv -----
package ferrt_pkg;

    localparam int COUNTER_WIDTH = 32;

    localparam logic [2:0] KIND_GOOD   = 3'd0;
    localparam logic [2:0] KIND_BAD    = 3'd1;
    localparam logic [2:0] KIND_STOLEN = 3'd2;
    localparam logic [2:0] KIND_BER    = 3'd3;
    localparam logic [2:0] KIND_CLEAR  = 3'd4;

    localparam logic [15:0] Q16_MAX = 16'hFFFF;
    localparam logic [15:0] SCORE_DROP = 16'd2;

    localparam int SUM_W = 24;
    localparam int EMA_SHIFT = 4;
    localparam int SCALE_IN_W = SUM_W - EMA_SHIFT;
    localparam int RECIP_W = 21;
    localparam int RECIP_SHIFT = 24;
    localparam int PROD_W = SCALE_IN_W + RECIP_W;
    localparam logic [SUM_W-1:0] EMA_KEEP = 24'd207;
    localparam logic [RECIP_W-1:0] EMA_RECIP = 21'd1290556;

    localparam int DIV_STEPS = 16;
    localparam int STEP_W = $clog2(DIV_STEPS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        OP_GOOD,
        OP_BAD,
        OP_STOLEN,
        OP_BER,
        OP_CLEAR,
        OP_NONE
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [3:0]  frame_count;
        logic [9:0]  bit_errors;
        logic [9:0]  frame_size;
        logic        ber_sat;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMA_SUM,
        ST_EMA_SCALE,
        ST_FINISH
    } t_state;

endpackage

// ----- design/ferrt_front.sv -----
module ferrt_front (
    input  logic               i_valid,
    input  logic [2:0]         i_kind,
    input  logic [3:0]         i_frame_count,
    input  logic [9:0]         i_bit_errors,
    input  logic [9:0]         i_frame_size,
    input  ferrt_pkg::t_q_status i_q_status,
    output logic               o_stall,
    output logic               o_push,
    output ferrt_pkg::t_cmd    o_cmd
);

    ferrt_pkg::t_op op;

    always_comb begin
        case (i_kind)
            ferrt_pkg::KIND_GOOD:   op = ferrt_pkg::OP_GOOD;
            ferrt_pkg::KIND_BAD:    op = ferrt_pkg::OP_BAD;
            ferrt_pkg::KIND_STOLEN: op = ferrt_pkg::OP_STOLEN;
            ferrt_pkg::KIND_BER:    op = ferrt_pkg::OP_BER;
            ferrt_pkg::KIND_CLEAR:  op = ferrt_pkg::OP_CLEAR;
            default:                op = ferrt_pkg::OP_NONE;
        endcase
    end

    // A sample saturates exactly when the error count reaches the frame size.
    assign o_cmd.op          = op;
    assign o_cmd.frame_count = i_frame_count;
    assign o_cmd.bit_errors  = i_bit_errors;
    assign o_cmd.frame_size  = i_frame_size;
    assign o_cmd.ber_sat     = (i_bit_errors >= i_frame_size);

    assign o_stall = i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;

endmodule

// ----- design/ferrt_queue.sv -----
`include "assert_macros.svh"

module ferrt_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  ferrt_pkg::t_cmd      i_cmd,
    input  logic                 i_pop,
    output ferrt_pkg::t_cmd      o_cmd,
    output ferrt_pkg::t_q_status o_status
);

    ferrt_pkg::t_cmd r_mem [ferrt_pkg::QDEPTH];
    logic [ferrt_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [ferrt_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [ferrt_pkg::QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_cmd          = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == ferrt_pkg::QCNT_W'(ferrt_pkg::QDEPTH));
    assign o_status.empty = (r_count == '0);

    `FERRT_ASSERT(a_count_bound, i_clk, i_rst_n,
        r_count <= ferrt_pkg::QCNT_W'(ferrt_pkg::QDEPTH))
    `FERRT_ASSERT(a_no_overflow, i_clk, i_rst_n, !(i_push && o_status.full))
    `FERRT_ASSERT(a_no_underflow, i_clk, i_rst_n, !(i_pop && o_status.empty))

endmodule

// ----- design/ferrt_back.sv -----
`include "assert_macros.svh"

module ferrt_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ferrt_pkg::t_cmd      i_cmd,
    input  ferrt_pkg::t_q_status i_q_status,
    output logic                 o_pop,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic [15:0]          o_average_fer,
    output logic [15:0]          o_average_ber,
    output logic [15:0]          o_latest_ber,
    output logic [31:0]          o_total_frames,
    output logic [31:0]          o_stolen_frames,
    output logic [31:0]          o_bad_frames,
    output logic [15:0]          o_bad_run_score
);

    localparam int CW = ferrt_pkg::COUNTER_WIDTH;

    ferrt_pkg::t_state r_state;
    ferrt_pkg::t_state n_state;
    ferrt_pkg::t_cmd   r_cmd;

    logic [9:0]  r_rem;
    logic [15:0] r_quo;
    logic [ferrt_pkg::STEP_W-1:0] r_step;
    logic [ferrt_pkg::SUM_W-1:0]  r_sum;
    logic [15:0] r_ema;

    logic [15:0]   r_fer_avg;
    logic [15:0]   r_ber_avg;
    logic [15:0]   r_ber_latest;
    logic [CW-1:0] r_total;
    logic [CW-1:0] r_stolen;
    logic [CW-1:0] r_bad;
    logic [15:0]   r_score;
    logic          r_out_valid;

    logic          out_free;
    logic          commit;
    logic [10:0]   trial;
    logic          ge;
    logic [9:0]    rem_next;
    logic [15:0]   sample;
    logic [15:0]   ema_avg;
    logic [15:0]   ema_x;
    logic [ferrt_pkg::PROD_W-1:0] scaled;
    logic [CW-1:0] frames;

    assign out_free = !r_out_valid || !i_stall;
    assign frames   = CW'(r_cmd.frame_count);

    // One restoring step of the bit error sample division.
    assign trial    = {r_rem, 1'b0};
    assign ge       = (trial >= {1'b0, r_cmd.frame_size});
    assign rem_next = ge ? 10'(trial - {1'b0, r_cmd.frame_size}) : trial[9:0];
    assign sample   = r_cmd.ber_sat ? ferrt_pkg::Q16_MAX : r_quo;

    always_comb begin
        case (r_cmd.op)
            ferrt_pkg::OP_BER: begin
                ema_avg = r_ber_avg;
                ema_x   = sample;
            end
            ferrt_pkg::OP_BAD: begin
                ema_avg = r_fer_avg;
                ema_x   = ferrt_pkg::Q16_MAX;
            end
            default: begin
                ema_avg = r_fer_avg;
                ema_x   = '0;
            end
        endcase
    end

    // The division by 208 is a shift by four and a reciprocal multiply for 13.
    assign scaled = ferrt_pkg::PROD_W'(r_sum[ferrt_pkg::SUM_W-1:ferrt_pkg::EMA_SHIFT])
                  * ferrt_pkg::PROD_W'(ferrt_pkg::EMA_RECIP);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ferrt_pkg::ST_IDLE: begin
                if (!i_q_status.empty) begin
                    case (i_cmd.op)
                        ferrt_pkg::OP_BER: begin
                            n_state = i_cmd.ber_sat ? ferrt_pkg::ST_EMA_SUM
                                                    : ferrt_pkg::ST_DIVIDE;
                        end
                        ferrt_pkg::OP_GOOD, ferrt_pkg::OP_BAD: begin
                            n_state = ferrt_pkg::ST_EMA_SUM;
                        end
                        default: n_state = ferrt_pkg::ST_FINISH;
                    endcase
                end
            end
            ferrt_pkg::ST_DIVIDE: begin
                if (r_step == ferrt_pkg::STEP_LAST) begin
                    n_state = ferrt_pkg::ST_EMA_SUM;
                end
            end
            ferrt_pkg::ST_EMA_SUM:   n_state = ferrt_pkg::ST_EMA_SCALE;
            ferrt_pkg::ST_EMA_SCALE: n_state = ferrt_pkg::ST_FINISH;
            ferrt_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_state = ferrt_pkg::ST_IDLE;
                end
            end
            default: n_state = ferrt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop  = 1'b0;
        commit = 1'b0;
        case (r_state)
            ferrt_pkg::ST_IDLE:   o_pop  = !i_q_status.empty;
            ferrt_pkg::ST_FINISH: commit = out_free;
            default: begin
                o_pop  = 1'b0;
                commit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ferrt_pkg::ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_step <= '0;
            end else if (r_state == ferrt_pkg::ST_DIVIDE) begin
                r_step <= r_step + 1'b1;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
            r_rem <= i_cmd.bit_errors;
            r_quo <= '0;
        end else if (r_state == ferrt_pkg::ST_DIVIDE) begin
            r_rem <= rem_next;
            r_quo <= {r_quo[14:0], ge};
        end
        if (r_state == ferrt_pkg::ST_EMA_SUM) begin
            r_sum <= ferrt_pkg::SUM_W'(ema_avg) * ferrt_pkg::EMA_KEEP
                   + ferrt_pkg::SUM_W'(ema_x);
        end
        if (r_state == ferrt_pkg::ST_EMA_SCALE) begin
            r_ema <= scaled[ferrt_pkg::RECIP_SHIFT +: 16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fer_avg    <= '0;
            r_ber_avg    <= '0;
            r_ber_latest <= '0;
            r_total      <= '0;
            r_stolen     <= '0;
            r_bad        <= '0;
            r_score      <= '0;
        end else if (commit) begin
            case (r_cmd.op)
                ferrt_pkg::OP_GOOD: begin
                    r_score   <= (r_score <= 16'd1) ? '0 : r_score - ferrt_pkg::SCORE_DROP;
                    r_fer_avg <= r_ema;
                    r_total   <= r_total + frames;
                end
                ferrt_pkg::OP_BAD: begin
                    if (r_score != ferrt_pkg::Q16_MAX) begin
                        r_score <= r_score + 1'b1;
                    end
                    r_fer_avg <= r_ema;
                    r_total   <= r_total + frames;
                    r_bad     <= r_bad + frames;
                end
                ferrt_pkg::OP_STOLEN: begin
                    r_total  <= r_total + frames;
                    r_stolen <= r_stolen + frames;
                end
                ferrt_pkg::OP_BER: begin
                    r_ber_latest <= sample;
                    r_ber_avg    <= r_ema;
                end
                ferrt_pkg::OP_CLEAR: begin
                    r_fer_avg <= '0;
                    r_ber_avg <= '0;
                    r_total   <= '0;
                    r_stolen  <= '0;
                    r_bad     <= '0;
                    r_score   <= '0;
                end
                default: r_score <= r_score;
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_average_fer   = r_fer_avg;
    assign o_average_ber   = r_ber_avg;
    assign o_latest_ber    = r_ber_latest;
    assign o_total_frames  = 32'(r_total);
    assign o_stolen_frames = 32'(r_stolen);
    assign o_bad_frames    = 32'(r_bad);
    assign o_bad_run_score = r_score;

    `FERRT_ASSERT(a_rem_below_size, i_clk, i_rst_n,
        (r_state == ferrt_pkg::ST_DIVIDE) |-> ({1'b0, r_rem} < {1'b0, r_cmd.frame_size}))
    `FERRT_ASSERT(a_ema_fits, i_clk, i_rst_n,
        (r_state == ferrt_pkg::ST_EMA_SCALE) |-> (scaled[ferrt_pkg::PROD_W-1:40] == '0))
    `FERRT_ASSERT_NEXT(a_held_result, i_clk, i_rst_n, r_out_valid && i_stall,
        $stable(r_total) && $stable(r_fer_avg) && $stable(r_ber_avg) && $stable(r_score))

endmodule

// ----- design/frame_error_rate_tracker_unit.sv -----
// Link quality monitor: each event item (good, bad or stolen frame, bit error
// sample, clear) yields one item carrying every statistic after that event.
// Events pass through a two-entry queue to an execution stage, so up to two
// further events are taken while one is being worked on or its result waits.
// A good or bad frame event passes from the queue through the averaging sum,
// scale and finish states; a stolen frame, clear or unused event goes straight
// to finish. A bit error sample first runs the 16-step serial divider that
// forms the sample, unless it saturates, and then the shared averaging
// multiply. A stalled result holds the execution stage in its finish state
// until the result is taken. Averages use weight 1/208 in unsigned Q0.16.
module frame_error_rate_tracker_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_kind,
    input  logic [3:0]  i_frame_count,
    input  logic [9:0]  i_bit_errors,
    input  logic [9:0]  i_frame_size,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_average_fer,
    output logic [15:0] o_average_ber,
    output logic [15:0] o_latest_ber,
    output logic [31:0] o_total_frames,
    output logic [31:0] o_stolen_frames,
    output logic [31:0] o_bad_frames,
    output logic [15:0] o_bad_run_score
);

    ferrt_pkg::t_cmd      push_cmd;
    ferrt_pkg::t_cmd      head_cmd;
    ferrt_pkg::t_q_status q_status;
    logic                 push;
    logic                 pop;

    ferrt_front u_front (
        .i_valid       (i_valid),
        .i_kind        (i_kind),
        .i_frame_count (i_frame_count),
        .i_bit_errors  (i_bit_errors),
        .i_frame_size  (i_frame_size),
        .i_q_status    (q_status),
        .o_stall       (o_stall),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    ferrt_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_cmd    (head_cmd),
        .o_status (q_status)
    );

    ferrt_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (head_cmd),
        .i_q_status      (q_status),
        .o_pop           (pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_average_fer   (o_average_fer),
        .o_average_ber   (o_average_ber),
        .o_latest_ber    (o_latest_ber),
        .o_total_frames  (o_total_frames),
        .o_stolen_frames (o_stolen_frames),
        .o_bad_frames    (o_bad_frames),
        .o_bad_run_score (o_bad_run_score)
    );

endmodule
